FILE: src/itq_pkg.sv
// Shared types and constants for the in-order trace queue with cursor.
package itq_pkg;

  localparam int unsigned IdW   = 64;
  localparam int unsigned PcW   = 64;
  localparam int unsigned StepW = 8;

  typedef enum logic [2:0] {
    REQ_APPEND = 3'd0,
    REQ_RETIRE = 3'd1,
    REQ_FLUSH  = 3'd2,
    REQ_SETCUR = 3'd3,
    REQ_STEP   = 3'd4,
    REQ_FIND   = 3'd5,
    REQ_CLEAR  = 3'd6,
    REQ_QUERY  = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_ID_GAP = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_ORDER  = 3'd3,
    ST_NO_ID  = 3'd4,
    ST_FULL   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FLUSH,
    S_FIND_RD,
    S_FIND_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic flush_drop;
    logic flush_end;
    logic scan_next;
    logic scan_hit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic empty;
    logic flush_more;
    logic pc_match;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

FILE: src/inorder_trace_queue_with_cursor.sv
// In-order trace queue with cursor: stream ports, controller and datapath.
// Sequence: a request is captured, executed, then loaded into the result register once
//   the output is free; flush drops entries newer than the given id one at a time, and find pc
//   reads then compares one PC store entry at a time until a match or the last entry.
// Requests: one at a time; the next input is taken only after the result is loaded.
// Reset: rst_ni low empties the queue and clears cursor and dummy-head; PC store not cleared.
module inorder_trace_queue_with_cursor #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // item_id [63:0], pc_value [127:64], step_count [135:128]
  input  logic [135:0] s_axis_tdata,
  // req_type [2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, found, found_id, steps_taken, entry_count, oldest_id, newest_id,
  // cursor_id, cursor_valid, has_next, in_dummy_head; zero padded to bytes
  output logic [((271 + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata
);
  import itq_pkg::*;

  localparam int unsigned CntW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OutBits = 271 + CntW;

  cmd_t cmd;
  sts_t sts;

  logic [2:0]       status;
  logic             found;
  logic [IdW-1:0]   found_id;
  logic [StepW-1:0] steps_taken;
  logic [CntW-1:0]  entry_count;
  logic [IdW-1:0]   oldest_id;
  logic [IdW-1:0]   newest_id;
  logic [IdW-1:0]   cursor_id;
  logic             cursor_valid;
  logic             has_next;
  logic             in_dummy_head;

  itq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CntW        (CntW)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (s_axis_tuser),
    .item_id_i       (s_axis_tdata[63:0]),
    .pc_value_i      (s_axis_tdata[127:64]),
    .step_count_i    (s_axis_tdata[135:128]),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .status_o        (status),
    .found_o         (found),
    .found_id_o      (found_id),
    .steps_taken_o   (steps_taken),
    .entry_count_o   (entry_count),
    .oldest_id_o     (oldest_id),
    .newest_id_o     (newest_id),
    .cursor_id_o     (cursor_id),
    .cursor_valid_o  (cursor_valid),
    .has_next_o      (has_next),
    .in_dummy_head_o (in_dummy_head)
  );

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[OutBits-1:0] = {in_dummy_head, has_next, cursor_valid, cursor_id,
                                 newest_id, oldest_id, entry_count, steps_taken,
                                 found_id, found, status};
  end

endmodule

FILE: src/itq_ctrl.sv
// Controller state machine that sequences one request through the datapath.
module itq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  itq_pkg::sts_t sts_i,
  output itq_pkg::cmd_t cmd_o
);
  import itq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        case (sts_i.req)
          REQ_FLUSH: state_d = S_FLUSH;
          REQ_FIND:  state_d = sts_i.empty ? S_DONE : S_FIND_RD;
          default:   state_d = S_DONE;
        endcase
      end
      S_FLUSH: begin
        if (sts_i.flush_more) begin
          cmd_o.flush_drop = 1'b1;
        end else begin
          cmd_o.flush_end = 1'b1;
          state_d         = S_DONE;
        end
      end
      S_FIND_RD: begin
        state_d = S_FIND_CMP;
      end
      S_FIND_CMP: begin
        if (sts_i.pc_match) begin
          cmd_o.scan_hit = 1'b1;
          state_d        = S_DONE;
        end else if (sts_i.scan_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = S_FIND_RD;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: src/itq_dp.sv
// Datapath: queue state, PC store, request and result registers.
module itq_dp #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned CntW        = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  itq_pkg::cmd_t               cmd_i,
  output itq_pkg::sts_t               sts_o,
  input  logic [2:0]                  req_type_i,
  input  logic [itq_pkg::IdW-1:0]     item_id_i,
  input  logic [itq_pkg::PcW-1:0]     pc_value_i,
  input  logic [itq_pkg::StepW-1:0]   step_count_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [2:0]                  status_o,
  output logic                        found_o,
  output logic [itq_pkg::IdW-1:0]     found_id_o,
  output logic [itq_pkg::StepW-1:0]   steps_taken_o,
  output logic [CntW-1:0]             entry_count_o,
  output logic [itq_pkg::IdW-1:0]     oldest_id_o,
  output logic [itq_pkg::IdW-1:0]     newest_id_o,
  output logic [itq_pkg::IdW-1:0]     cursor_id_o,
  output logic                        cursor_valid_o,
  output logic                        has_next_o,
  output logic                        in_dummy_head_o
);
  import itq_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned SumW = PtrW + 1;
  localparam int unsigned MvW  = (CntW > StepW) ? CntW : StepW;
  localparam logic [PtrW-1:0] LastSlot  = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [SumW-1:0] DepthSum  = SumW'(QUEUE_DEPTH);
  localparam logic [CntW-1:0] DepthCnt  = CntW'(QUEUE_DEPTH);

  logic [PcW-1:0] pc_mem [QUEUE_DEPTH];

  req_e             req_q, req_d;
  logic [IdW-1:0]   id_q, id_d;
  logic [PcW-1:0]   pc_q, pc_d;
  logic [StepW-1:0] n_q, n_d;

  logic [PtrW-1:0]  head_q, head_d;
  logic [CntW-1:0]  total_q, total_d;
  logic [IdW-1:0]   oldest_q, oldest_d;
  logic [IdW-1:0]   newest_q, newest_d;
  logic [PtrW-1:0]  cursor_q, cursor_d;
  logic             dummy_q, dummy_d;

  status_e          status_q, status_d;
  logic             found_q, found_d;
  logic [IdW-1:0]   found_id_q, found_id_d;
  logic [StepW-1:0] taken_q, taken_d;
  logic [PtrW-1:0]  scan_k_q, scan_k_d;
  logic [PtrW-1:0]  scan_addr_q, scan_addr_d;
  logic [PcW-1:0]   rd_q;
  logic             out_valid_q, out_valid_d;

  logic             mem_we;
  logic [SumW-1:0]  wsum;
  logic [PtrW-1:0]  wslot;
  logic [IdW-1:0]   id_diff;
  logic [CntW-1:0]  last_cnt;
  logic [PtrW-1:0]  last_off;
  logic [CntW-1:0]  cursor_cnt;
  logic [CntW-1:0]  avail;
  logic [StepW-1:0] left1;
  logic [MvW-1:0]   move;
  logic             nonempty;

  assign nonempty   = (total_q != '0);
  assign last_cnt   = total_q - 1'b1;
  assign last_off   = last_cnt[PtrW-1:0];
  assign cursor_cnt = CntW'(cursor_q);
  assign avail      = last_cnt - cursor_cnt;
  assign left1      = n_q - StepW'(dummy_q);
  assign move       = (MvW'(left1) < MvW'(avail)) ? MvW'(left1) : MvW'(avail);
  assign wsum       = SumW'(head_q) + SumW'(total_q);
  assign wslot      = (wsum >= DepthSum) ? PtrW'(wsum - DepthSum) : PtrW'(wsum);
  assign id_diff    = id_q - oldest_q;

  always_comb begin
    req_d       = req_q;
    id_d        = id_q;
    pc_d        = pc_q;
    n_d         = n_q;
    head_d      = head_q;
    total_d     = total_q;
    oldest_d    = oldest_q;
    newest_d    = newest_q;
    cursor_d    = cursor_q;
    dummy_d     = dummy_q;
    status_d    = status_q;
    found_d     = found_q;
    found_id_d  = found_id_q;
    taken_d     = taken_q;
    scan_k_d    = scan_k_q;
    scan_addr_d = scan_addr_q;
    mem_we      = 1'b0;

    if (cmd_i.capture) begin
      req_d = req_e'(req_type_i);
      id_d  = item_id_i;
      pc_d  = pc_value_i;
      n_d   = step_count_i;
    end

    if (cmd_i.exec) begin
      status_d   = ST_OK;
      found_d    = 1'b0;
      found_id_d = '0;
      taken_d    = '0;
      case (req_q)
        REQ_APPEND: begin
          if (nonempty && (id_q != newest_q + 1'b1)) begin
            status_d = ST_ID_GAP;
          end else if (total_q == DepthCnt) begin
            status_d = ST_FULL;
          end else begin
            if (!nonempty) begin
              oldest_d = id_q;
            end
            newest_d = id_q;
            mem_we   = 1'b1;
            total_d  = total_q + 1'b1;
            cursor_d = PtrW'(total_q);
            dummy_d  = 1'b0;
          end
        end
        REQ_RETIRE: begin
          if (!nonempty) begin
            status_d = ST_EMPTY;
          end else if (id_q != oldest_q) begin
            status_d = ST_ORDER;
          end else begin
            if (cursor_q == '0) begin
              dummy_d = 1'b1;
            end else begin
              cursor_d = cursor_q - 1'b1;
            end
            head_d   = (head_q == LastSlot) ? '0 : head_q + 1'b1;
            oldest_d = oldest_q + 1'b1;
            total_d  = total_q - 1'b1;
          end
        end
        REQ_SETCUR: begin
          if (!nonempty || (id_q < oldest_q) || (id_q > newest_q)) begin
            status_d = ST_NO_ID;
          end else begin
            dummy_d  = 1'b0;
            cursor_d = id_diff[PtrW-1:0];
          end
        end
        REQ_STEP: begin
          if (!nonempty) begin
            status_d = ST_EMPTY;
          end else if (n_q != '0) begin
            dummy_d  = 1'b0;
            cursor_d = cursor_q + PtrW'(move);
            taken_d  = StepW'(dummy_q) + StepW'(move);
          end
        end
        REQ_FIND: begin
          scan_k_d    = '0;
          scan_addr_d = head_q;
        end
        REQ_CLEAR: begin
          total_d  = '0;
          cursor_d = '0;
          dummy_d  = 1'b0;
        end
        default: ;
      endcase
    end

    if (cmd_i.flush_drop) begin
      total_d  = total_q - 1'b1;
      newest_d = newest_q - 1'b1;
      if ((cursor_cnt == last_cnt) && (cursor_q != '0)) begin
        cursor_d = cursor_q - 1'b1;
      end
    end

    if (cmd_i.flush_end) begin
      if (!nonempty) begin
        cursor_d = '0;
      end else if (cursor_cnt > last_cnt) begin
        cursor_d = last_off;
      end
    end

    if (cmd_i.scan_next) begin
      scan_k_d    = scan_k_q + 1'b1;
      scan_addr_d = (scan_addr_q == LastSlot) ? '0 : scan_addr_q + 1'b1;
    end

    if (cmd_i.scan_hit) begin
      found_d    = 1'b1;
      found_id_d = oldest_q + IdW'(scan_k_q);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      total_q     <= '0;
      oldest_q    <= '0;
      newest_q    <= '0;
      cursor_q    <= '0;
      dummy_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      total_q     <= total_d;
      oldest_q    <= oldest_d;
      newest_q    <= newest_d;
      cursor_q    <= cursor_d;
      dummy_q     <= dummy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    id_q        <= id_d;
    pc_q        <= pc_d;
    n_q         <= n_d;
    status_q    <= status_d;
    found_q     <= found_d;
    found_id_q  <= found_id_d;
    taken_q     <= taken_d;
    scan_k_q    <= scan_k_d;
    scan_addr_q <= scan_addr_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pc_mem[wslot] <= pc_q;
    end
    rd_q <= pc_mem[scan_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o        <= status_q;
      found_o         <= found_q;
      found_id_o      <= found_id_q;
      steps_taken_o   <= taken_q;
      entry_count_o   <= total_q;
      oldest_id_o     <= nonempty ? oldest_q : '0;
      newest_id_o     <= nonempty ? newest_q : '0;
      cursor_id_o     <= nonempty ? oldest_q + IdW'(cursor_q) : '0;
      cursor_valid_o  <= nonempty;
      has_next_o      <= nonempty && (cursor_cnt < last_cnt);
      in_dummy_head_o <= dummy_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sts_o.req        = req_q;
  assign sts_o.empty      = !nonempty;
  assign sts_o.flush_more = nonempty && (newest_q > id_q);
  assign sts_o.pc_match   = (rd_q == pc_q);
  assign sts_o.scan_last  = (CntW'(scan_k_q) == last_cnt);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= DepthCnt)
    else $error("entry total exceeds queue depth");

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nonempty |-> (cursor_cnt < total_q))
    else $error("cursor beyond newest entry");

  a_cursor_zero_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !nonempty |-> (cursor_q == '0))
    else $error("cursor nonzero on empty queue");

  a_newest_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nonempty |-> (newest_q == oldest_q + IdW'(last_cnt)))
    else $error("newest id out of step with oldest id and count");

endmodule
